>>> sv/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int PAT_WORD_W  = 64;
    localparam int MASK_W      = 16;
    localparam int LENGTH_W    = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WILDCARD     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH       = 2'd3;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 5'd1;

    // Region marks of one input word
    typedef struct packed {
        logic first;
        logic last;
    } region_marks_t;

    // One result word
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] match_start;
        logic              region_miss;
    } scan_result_t;

endpackage

>>> sv/wildcard_byte_pattern_scanner_top.sv
// Top level of the wildcard byte pattern scanner: handshake, config and stage registers.
// A word is held in the input register, then its result word in the result register.
// Throughput: one byte per cycle unless m_tready stalls the result register; the window
// and found mark are read and rewritten as a word moves into the result register.
// Reset (rst_n low, asynchronous): empty window, no match found, pattern and
// mask zero, pattern length one; both stage registers empty.
module wildcard_byte_pattern_scanner_top #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // data_byte [7:0], byte_address [39:8]
    input  logic        s_tuser,    // region_first
    input  logic        s_tlast,    // region_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // match_start [31:0]
    output logic [1:0]  m_tuser,    // hit [0], region_miss [1]
    input  logic        cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    logic [wbps_pkg::PAT_WORD_W-1:0] pattern_low_reg;
    logic [wbps_pkg::PAT_WORD_W-1:0] pattern_high_reg;
    logic [wbps_pkg::MASK_W-1:0]     wildcard_mask_reg;
    logic [wbps_pkg::LENGTH_W-1:0]   pattern_length_reg;

    logic                          in_valid_reg;
    logic [wbps_pkg::DATA_W-1:0]   in_data_reg;
    logic [wbps_pkg::ADDR_W-1:0]   in_addr_reg;
    wbps_pkg::region_marks_t       in_marks_reg;

    logic                          out_valid_reg;
    wbps_pkg::scan_result_t        out_result_reg;

    logic                                      advance;
    logic [MAX_PATTERN_BYTES*wbps_pkg::DATA_W-1:0] window_next;
    logic [LEN_W-1:0]                          fill_next;
    logic                                      found_cur;
    wbps_pkg::scan_result_t                    result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= wbps_pkg::LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LOW:  pattern_low_reg    <= cfg_wdata;
                wbps_pkg::CFG_PATTERN_HIGH: pattern_high_reg   <= cfg_wdata;
                wbps_pkg::CFG_WILDCARD:     wildcard_mask_reg  <= cfg_wdata[wbps_pkg::MASK_W-1:0];
                wbps_pkg::CFG_LENGTH:       pattern_length_reg <= cfg_wdata[wbps_pkg::LENGTH_W-1:0];
                default:                    pattern_length_reg <= pattern_length_reg;
            endcase
        end
    end

    // Move the held word into the result register when that slot frees up
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg        <= s_tdata[7:0];
            in_addr_reg        <= s_tdata[39:8];
            in_marks_reg.first <= s_tuser;
            in_marks_reg.last  <= s_tlast;
        end
    end

    wbps_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .data_byte   (in_data_reg),
        .marks       (in_marks_reg),
        .hit         (result.hit),
        .window_next (window_next),
        .fill_next   (fill_next),
        .found_cur   (found_cur)
    );

    wbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .window_next    (window_next),
        .fill_next      (fill_next),
        .found_cur      (found_cur),
        .region_last    (in_marks_reg.last),
        .byte_address   (in_addr_reg),
        .pattern_low    (pattern_low_reg),
        .pattern_high   (pattern_high_reg),
        .wildcard_mask  (wildcard_mask_reg),
        .pattern_length (pattern_length_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_result_reg.match_start;
    assign m_tuser[0] = out_result_reg.hit;
    assign m_tuser[1] = out_result_reg.region_miss;

endmodule

>>> sv/wbps_window.sv
// Byte window, fill count and found mark of the current region.
module wbps_window #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     advance,
    input  logic [wbps_pkg::DATA_W-1:0]              data_byte,
    input  wbps_pkg::region_marks_t                  marks,
    input  logic                                     hit,
    output logic [MAX_PATTERN_BYTES*wbps_pkg::DATA_W-1:0] window_next,
    output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]   fill_next,
    output logic                                     found_cur
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int DW    = wbps_pkg::DATA_W;

    logic [DW-1:0]    window_reg [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0] fill_reg;
    logic             found_reg;

    // Shift in the new byte; a region start drops everything older
    always_comb
    begin
        window_next[DW-1:0] = data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
        begin
            window_next[k*DW +: DW] = marks.first ? '0 : window_reg[k-1];
        end
    end

    always_comb
    begin
        if (marks.first)
        begin
            fill_next = LEN_W'(1);
        end
        else if (fill_reg == LEN_W'(MAX_PATTERN_BYTES))
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + LEN_W'(1);
        end
    end

    assign found_cur = found_reg & ~marks.first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
            begin
                window_reg[k] <= '0;
            end
            fill_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
            begin
                window_reg[k] <= window_next[k*DW +: DW];
            end
            fill_reg  <= fill_next;
            found_reg <= found_cur | hit;
        end
    end

endmodule

>>> sv/wbps_match.sv
// Masked compare of the window against the pattern and result forming.
module wbps_match #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic [MAX_PATTERN_BYTES*wbps_pkg::DATA_W-1:0] window_next,
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]   fill_next,
    input  logic                                     found_cur,
    input  logic                                     region_last,
    input  logic [wbps_pkg::ADDR_W-1:0]              byte_address,
    input  logic [wbps_pkg::PAT_WORD_W-1:0]          pattern_low,
    input  logic [wbps_pkg::PAT_WORD_W-1:0]          pattern_high,
    input  logic [wbps_pkg::MASK_W-1:0]              wildcard_mask,
    input  logic [wbps_pkg::LENGTH_W-1:0]            pattern_length,
    output wbps_pkg::scan_result_t                   result
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int DW    = wbps_pkg::DATA_W;

    logic [2*wbps_pkg::PAT_WORD_W-1:0] pattern_all;
    logic [DW-1:0]                     window_arr [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0]                  used_len;
    logic [MAX_PATTERN_BYTES-1:0]      byte_ok;
    logic                              match;

    assign pattern_all = {pattern_high, pattern_low};

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            window_arr[k] = window_next[k*DW +: DW];
        end
    end

    // Clamp the length to 1..MAX_PATTERN_BYTES
    always_comb
    begin
        if (pattern_length == '0)
        begin
            used_len = LEN_W'(1);
        end
        else if (pattern_length > wbps_pkg::LENGTH_W'(MAX_PATTERN_BYTES))
        begin
            used_len = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            used_len = LEN_W'(pattern_length);
        end
    end

    // Pattern byte i lines up with the byte of age used_len-1-i
    always_comb
    begin
        logic [LEN_W-1:0] age;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            age = used_len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) >= used_len || wildcard_mask[i])
            begin
                byte_ok[i] = 1'b1;
            end
            else
            begin
                byte_ok[i] = (window_arr[age[IDX_W-1:0]] == pattern_all[i*DW +: DW]);
            end
        end
    end

    assign match = (fill_next >= used_len) && (&byte_ok);

    always_comb
    begin
        result.hit         = ~found_cur & match;
        result.match_start = result.hit
                           ? byte_address - wbps_pkg::ADDR_W'(used_len - LEN_W'(1))
                           : '0;
        result.region_miss = region_last & ~(found_cur | match);
    end

endmodule
